// ===== hdl/sed_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sed_pkg
// shared types, character codes and the hex digit helper of the string
// escape decoder
// ----------------------------------------------------------------------------
package sed_pkg;

    typedef logic [7:0] byte_t;

    typedef enum logic [2:0] {
        MODE_NORMAL   = 3'd0,
        MODE_ESCAPE   = 3'd1,
        MODE_HEX1     = 3'd2,
        MODE_HEX2     = 3'd3,
        MODE_SUPPRESS = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNCLOSED  = 2'd1,
        ST_UNDEF_ESC = 2'd2,
        ST_UNDEF_HEX = 2'd3
    } status_t;

    localparam byte_t CH_QUOTE  = 8'h22;
    localparam byte_t CH_BSLASH = 8'h5C;
    localparam byte_t CH_N      = 8'h6E;
    localparam byte_t CH_R      = 8'h72;
    localparam byte_t CH_T      = 8'h74;
    localparam byte_t CH_ZERO   = 8'h30;
    localparam byte_t CH_X      = 8'h78;
    localparam byte_t CH_UA     = 8'h41;
    localparam byte_t CH_LA     = 8'h61;
    localparam byte_t CH_LF     = 8'h0A;
    localparam byte_t CH_CR     = 8'h0D;
    localparam byte_t CH_TAB    = 8'h09;

    // largest value a hex escape may produce
    localparam byte_t HEX_MAX   = 8'd127;
    // marker for "not a hex digit"
    localparam logic [4:0] HEX_NONE = 5'd16;

    // value of a hex digit, or HEX_NONE
    function automatic logic [4:0] hex_digit(input byte_t c);
        byte_t d;
        d = 8'd0;
        if (c inside {[8'h30:8'h39]}) begin
            d = c - CH_ZERO;
        end else if (c inside {[8'h41:8'h46]}) begin
            d = c - CH_UA + 8'd10;
        end else if (c inside {[8'h61:8'h66]}) begin
            d = c - CH_LA + 8'd10;
        end else begin
            d = {3'd0, HEX_NONE};
        end
        return d[4:0];
    endfunction

endpackage
`default_nettype wire

// ===== hdl/string_escape_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// string_escape_decoder
// decodes a quoted string literal one raw byte per request, one result each
// ----------------------------------------------------------------------------
// Every accepted input byte yields exactly one result request in the next
// cycle, and a new byte is taken in every cycle while the result side keeps
// up: the per-byte mode update and decode is a single shallow level of logic
// between the decoder state registers and the result register, so the rate
// is one byte per clock. The result register also acts as the output stage:
// while it holds an untaken result a new byte is accepted only in the cycle
// in which that result leaves. Errors stay in force until the byte marked
// last, after which all decoder state starts fresh for the next literal.
// ----------------------------------------------------------------------------
module string_escape_decoder (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_valid,
    output logic             s_ready,
    input  sed_pkg::byte_t   s_in_byte,
    input  wire              s_in_last,
    output logic             m_valid,
    input  wire              m_ready,
    output logic             m_out_valid,
    output sed_pkg::byte_t   m_out_byte,
    output logic             m_out_last,
    output logic [1:0]       m_status,
    output sed_pkg::byte_t   m_err_first,
    output sed_pkg::byte_t   m_err_second,
    output logic [1:0]       m_err_count
);
    import sed_pkg::*;

    // decoder state
    mode_t      mode_reg,     mode_next;
    byte_t      hex_high_reg, hex_high_next;
    status_t    err_code_reg, err_code_next;
    byte_t      err_a_reg,    err_a_next;
    byte_t      err_b_reg,    err_b_next;
    logic [1:0] err_len_reg,  err_len_next;

    // result register
    logic       m_valid_reg;
    logic       out_valid_reg, out_valid_next;
    byte_t      out_byte_reg,  out_byte_next;
    logic       out_last_reg;
    status_t    status_reg;
    byte_t      err_first_reg;
    byte_t      err_second_reg;
    logic [1:0] err_count_reg;

    logic       accept;
    logic [4:0] hex_h;
    logic [4:0] hex_l;
    logic       hex_ok;

    // take a byte whenever the result slot is empty or being drained
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign hex_h  = hex_digit(hex_high_reg);
    assign hex_l  = hex_digit(s_in_byte);
    // both digits valid and the value at most 127 means a high digit below 8
    assign hex_ok = (hex_h != HEX_NONE) && (hex_l != HEX_NONE)
                    && ({hex_h[3:0], hex_l[3:0]} <= HEX_MAX);

    // per-byte decode
    always_comb begin
        mode_next      = mode_reg;
        hex_high_next  = hex_high_reg;
        err_code_next  = err_code_reg;
        err_a_next     = err_a_reg;
        err_b_next     = err_b_reg;
        err_len_next   = err_len_reg;
        out_valid_next = 1'b0;
        out_byte_next  = 8'd0;

        // a sticky error freezes everything until the literal ends
        if (err_code_reg == ST_OK) begin
            case (mode_reg)
                MODE_ESCAPE: begin
                    mode_next = MODE_NORMAL;
                    if (s_in_last) begin
                        // escape char is the final byte: never closed
                        err_code_next = ST_UNCLOSED;
                        err_a_next    = 8'd0;
                        err_b_next    = 8'd0;
                        err_len_next  = 2'd0;
                    end else if (s_in_byte == CH_BSLASH || s_in_byte == CH_QUOTE) begin
                        out_valid_next = 1'b1;
                        out_byte_next  = s_in_byte;
                    end else if (s_in_byte == CH_N) begin
                        out_valid_next = 1'b1;
                        out_byte_next  = CH_LF;
                    end else if (s_in_byte == CH_R) begin
                        out_valid_next = 1'b1;
                        out_byte_next  = CH_CR;
                    end else if (s_in_byte == CH_T) begin
                        out_valid_next = 1'b1;
                        out_byte_next  = CH_TAB;
                    end else if (s_in_byte == CH_ZERO) begin
                        mode_next = MODE_SUPPRESS;
                    end else if (s_in_byte == CH_X) begin
                        mode_next = MODE_HEX1;
                    end else begin
                        err_code_next = ST_UNDEF_ESC;
                        err_a_next    = s_in_byte;
                        err_b_next    = 8'd0;
                        err_len_next  = 2'd1;
                    end
                end
                MODE_HEX1: begin
                    if (s_in_last) begin
                        // literal ends after the first digit
                        mode_next     = MODE_NORMAL;
                        err_code_next = ST_UNDEF_HEX;
                        err_a_next    = s_in_byte;
                        err_b_next    = 8'd0;
                        err_len_next  = 2'd1;
                    end else begin
                        hex_high_next = s_in_byte;
                        mode_next     = MODE_HEX2;
                    end
                end
                MODE_HEX2: begin
                    mode_next = MODE_NORMAL;
                    if (hex_ok) begin
                        out_valid_next = 1'b1;
                        out_byte_next  = {hex_h[3:0], hex_l[3:0]};
                    end else begin
                        err_code_next = ST_UNDEF_HEX;
                        err_a_next    = hex_high_reg;
                        err_b_next    = s_in_byte;
                        err_len_next  = 2'd2;
                    end
                end
                MODE_SUPPRESS: begin
                    // everything after backslash-0 is dropped
                end
                default: begin
                    mode_next = MODE_NORMAL;
                    if (s_in_byte == CH_QUOTE) begin
                        // bare quote dropped
                    end else if (s_in_byte == CH_BSLASH) begin
                        if (s_in_last) begin
                            err_code_next = ST_UNCLOSED;
                            err_a_next    = 8'd0;
                            err_b_next    = 8'd0;
                            err_len_next  = 2'd0;
                        end else begin
                            mode_next = MODE_ESCAPE;
                        end
                    end else begin
                        out_valid_next = 1'b1;
                        out_byte_next  = s_in_byte;
                    end
                end
            endcase
        end
    end

    // decoder state, cleared again after the final byte of each literal
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_NORMAL;
            hex_high_reg <= 8'd0;
            err_code_reg <= ST_OK;
            err_a_reg    <= 8'd0;
            err_b_reg    <= 8'd0;
            err_len_reg  <= 2'd0;
        end else if (accept) begin
            if (s_in_last) begin
                mode_reg     <= MODE_NORMAL;
                hex_high_reg <= 8'd0;
                err_code_reg <= ST_OK;
                err_a_reg    <= 8'd0;
                err_b_reg    <= 8'd0;
                err_len_reg  <= 2'd0;
            end else begin
                mode_reg     <= mode_next;
                hex_high_reg <= hex_high_next;
                err_code_reg <= err_code_next;
                err_a_reg    <= err_a_next;
                err_b_reg    <= err_b_next;
                err_len_reg  <= err_len_next;
            end
        end
    end

    // result slot valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload, loaded with the status as it stands after this byte
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_valid_reg  <= out_valid_next;
            out_byte_reg   <= out_byte_next;
            out_last_reg   <= s_in_last;
            status_reg     <= err_code_next;
            err_first_reg  <= err_a_next;
            err_second_reg <= err_b_next;
            err_count_reg  <= err_len_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_valid  = out_valid_reg;
    assign m_out_byte   = out_byte_reg;
    assign m_out_last   = out_last_reg;
    assign m_status     = status_reg;
    assign m_err_first  = err_first_reg;
    assign m_err_second = err_second_reg;
    assign m_err_count  = err_count_reg;

endmodule
`default_nettype wire

// ===== hdl/sed_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sed_checker
// port-level checks on the result channel of the string escape decoder
// ----------------------------------------------------------------------------
module sed_checker (
    input wire              aclk,
    input wire              aresetn,
    input wire              m_valid,
    input wire              m_ready,
    input wire              m_out_valid,
    input sed_pkg::byte_t   m_out_byte,
    input wire              m_out_last,
    input wire [1:0]        m_status,
    input wire [1:0]        m_err_count
);
    import sed_pkg::*;

    // a stalled result request holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_status))
        else $error("stalled result changed");

    // no character comes out while an error stands
    a_err_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> !m_out_valid && m_out_byte == 8'd0)
        else $error("character emitted under error");

    // unclosed can only be raised on the literal's final byte
    a_unclosed_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_UNCLOSED |-> m_out_last && m_err_count == 2'd0)
        else $error("unclosed error away from the final byte");

    // detail count matches the error kind
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_OK && m_err_count == 2'd0)
                 || (m_status == ST_UNCLOSED && m_err_count == 2'd0)
                 || (m_status == ST_UNDEF_ESC && m_err_count == 2'd1)
                 || (m_status == ST_UNDEF_HEX
                     && (m_err_count == 2'd1 || m_err_count == 2'd2)))
        else $error("error detail count inconsistent");

endmodule

bind string_escape_decoder sed_checker u_sed_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_valid (m_out_valid),
    .m_out_byte  (m_out_byte),
    .m_out_last  (m_out_last),
    .m_status    (m_status),
    .m_err_count (m_err_count)
);
`default_nettype wire
